@@ rtl/typed_block_deframer_top_defines.svh @@
// Assertion macros shared by the typed block deframer RTL.
`ifndef TYPED_BLOCK_DEFRAMER_TOP_DEFINES_SVH
`define TYPED_BLOCK_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of i_clk while the block is out of reset.
`define TBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge of i_clk, reset included.
`define TBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TBD_ASSERT(lbl, prop, msg)
`define TBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/tbd_pkg.sv @@
// Package with the types, constants and codes of the typed block deframer.
package tbd_pkg;

    localparam int NUM_TYPES       = 16;
    localparam int FRAME_WORDS_MAX = 64;

    localparam int TYPE_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int FRAME_W = $clog2(FRAME_WORDS_MAX + 1);
    localparam int PAY_W   = 15;
    localparam int MASK_W  = 16;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_READBACK = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  frame_words;
        logic [31:0] data_word;
        logic [3:0]  type_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] block_type;
        logic [15:0] byte_length;
        logic [31:0] payload_word;
        logic        last_of_block;
        logic        truncated;
        logic [31:0] type_count;
    } t_out_item;

    typedef struct packed {
        logic              inc;
        logic [TYPE_W-1:0] inc_idx;
        logic [TYPE_W-1:0] rd_idx;
    } t_cnt_ctl;

endpackage

@@ rtl/typed_block_deframer_top.sv @@
// Top level of the typed block deframer: input register, decode and result register.
//
// The block takes one request per clock cycle. The request lands in an input
// register and is decoded by the parser against the frame and block state.
// The result, if there is one, is decoded from the request held in the
// input register and written to an output register when that register is
// empty or drained. It is held in the output register until the consumer
// takes it. A begin request arms a frame of up to FRAME_WORDS_MAX words. Each
// data request inside the frame is either a block header (type in the upper
// 16 bits, byte length in the lower 16) or a payload word of the current
// block. Headers of types below NUM_TYPES are counted. Blocks whose bit is set
// in the handler enable mask are forwarded header first, then each payload
// word. A counter read request always returns one result. Data words outside
// a frame and the unused command code give no result. Throughput is limited
// only by the output register: while a result sits there stalled, the input
// register holds its request and o_in_stall is raised. The configuration port
// is always ready and should only be written while no request is in flight.
`include "typed_block_deframer_top_defines.svh"

module typed_block_deframer_top
    import tbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [MASK_W-1:0] r_mask;

    logic      adv;
    logic      go;
    t_cnt_ctl  cnt_ctl;
    logic [31:0] rd_count;
    logic      emit;
    t_out_item result;

    // The result register can take a new result when it is empty or drained now.
    assign adv        = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    // Input register: loads whenever it is not holding a stalled request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= go && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    tbd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_item     (r_in),
        .i_mask     (r_mask),
        .i_rd_count (rd_count),
        .o_ctl      (cnt_ctl),
        .o_emit     (emit),
        .o_result   (result)
    );

    tbd_counters u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cnt_ctl),
        .o_rd_count (rd_count)
    );

    // A stall toward the producer is only raised while a request is held.
    `TBD_ASSERT(a_stall_needs_item, o_in_stall |-> r_in_valid, "stall without held request")
    // A counter read that goes through always produces a readback result.
    `TBD_ASSERT(a_read_gives_result,
        (go && (r_in.command == CMD_READ)) |=> (r_out_valid && (r_out.kind == KIND_READBACK)),
        "counter read lost")
    // A held request is kept until the parser takes it.
    `TBD_ASSERT(a_held_request_kept,
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)),
        "held request changed")

endmodule

@@ rtl/tbd_counters.sv @@
// Per-type block counters with one increment and one readback port.
module tbd_counters
    import tbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cnt_ctl    i_ctl,
    output logic [31:0] o_rd_count
);

    logic [31:0] r_cnt [NUM_TYPES];

    // Each counter is its own cell and only bumps when the header hits it.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= '0;
            end else if (i_ctl.inc && (i_ctl.inc_idx == TYPE_W'(i))) begin
                r_cnt[i] <= r_cnt[i] + 32'd1;
            end
        end
    end

    assign o_rd_count = r_cnt[i_ctl.rd_idx];

endmodule

@@ rtl/tbd_parser.sv @@
// Frame and block state plus the decode of one registered request.
module tbd_parser
    import tbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  t_in_item          i_item,
    input  logic [MASK_W-1:0] i_mask,
    input  logic [31:0]       i_rd_count,
    output t_cnt_ctl          o_ctl,
    output logic              o_emit,
    output t_out_item         o_result
);

    logic [FRAME_W-1:0] r_frame_left, n_frame_left;
    logic [PAY_W-1:0]   r_payload_left, n_payload_left;
    logic [15:0]        r_cur_type, n_cur_type;
    logic [15:0]        r_cur_len, n_cur_len;
    logic               r_cur_fwd, n_cur_fwd;

    logic [15:0]      hdr_type;
    logic [15:0]      hdr_len;
    logic             hdr_in_range;
    logic             hdr_fwd;
    logic [PAY_W-1:0] hdr_plen;
    logic [PAY_W-1:0] pay_next;
    logic             ended;
    logic [15:0]      rd_type;

    assign hdr_type     = i_item.data_word[31:16];
    assign hdr_len      = i_item.data_word[15:0];
    assign hdr_in_range = 32'(hdr_type) < NUM_TYPES;
    assign hdr_fwd      = hdr_in_range && (hdr_type[15:4] == 12'd0) && i_mask[hdr_type[3:0]];
    assign hdr_plen     = PAY_W'((17'(hdr_len) + 17'd3) >> 2);
    assign pay_next     = r_payload_left - PAY_W'(1);
    assign ended        = (r_frame_left == FRAME_W'(1));
    assign rd_type      = {12'd0, i_item.type_index};

    always_comb begin
        n_frame_left   = r_frame_left;
        n_payload_left = r_payload_left;
        n_cur_type     = r_cur_type;
        n_cur_len      = r_cur_len;
        n_cur_fwd      = r_cur_fwd;
        o_emit         = 1'b0;
        o_result       = '0;
        o_ctl.inc      = 1'b0;
        o_ctl.inc_idx  = hdr_type[TYPE_W-1:0];
        o_ctl.rd_idx   = rd_type[TYPE_W-1:0];

        if (i_go) begin
            case (i_item.command)
                CMD_BEGIN: begin
                    n_frame_left   = (32'(i_item.frame_words) > FRAME_WORDS_MAX)
                                   ? FRAME_W'(FRAME_WORDS_MAX)
                                   : FRAME_W'(i_item.frame_words);
                    n_payload_left = '0;
                    n_cur_fwd      = 1'b0;
                end
                CMD_READ: begin
                    o_emit              = 1'b1;
                    o_result.kind       = KIND_READBACK;
                    o_result.block_type = rd_type;
                    o_result.type_count = (32'(i_item.type_index) < NUM_TYPES)
                                        ? i_rd_count : 32'd0;
                end
                CMD_DATA: begin
                    if (r_frame_left != '0) begin
                        n_frame_left = r_frame_left - FRAME_W'(1);
                        if (r_payload_left == '0) begin
                            // A new block header.
                            n_cur_type             = hdr_type;
                            n_cur_len              = hdr_len;
                            n_cur_fwd              = hdr_fwd;
                            n_payload_left         = ended ? '0 : hdr_plen;
                            o_ctl.inc              = hdr_in_range;
                            o_emit                 = hdr_fwd;
                            o_result.kind          = KIND_HEADER;
                            o_result.block_type    = hdr_type;
                            o_result.byte_length   = hdr_len;
                            o_result.last_of_block = (hdr_plen == '0) || ended;
                            o_result.truncated     = (hdr_plen != '0) && ended;
                        end else begin
                            n_payload_left         = ended ? '0 : pay_next;
                            o_emit                 = r_cur_fwd;
                            o_result.kind          = KIND_PAYLOAD;
                            o_result.block_type    = r_cur_type;
                            o_result.byte_length   = r_cur_len;
                            o_result.payload_word  = i_item.data_word;
                            o_result.last_of_block = (pay_next == '0) || ended;
                            o_result.truncated     = (pay_next != '0) && ended;
                        end
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_left   <= '0;
            r_payload_left <= '0;
            r_cur_type     <= '0;
            r_cur_len      <= '0;
            r_cur_fwd      <= 1'b0;
        end else begin
            r_frame_left   <= n_frame_left;
            r_payload_left <= n_payload_left;
            r_cur_type     <= n_cur_type;
            r_cur_len      <= n_cur_len;
            r_cur_fwd      <= n_cur_fwd;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the typed block deframer: directed table, random frames, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbd_pkg::*;

    // Command code that the block has no use for; it must be dropped silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 48;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 200;

    localparam t_out_item NO_RESULT = '0;

    // One request on its way to the block. A pinned request carries the result
    // that is typed into the directed table; all others are left to the predictor.
    typedef struct packed {
        t_in_item  item;
        logic      pinned;
        t_out_item want;
    } t_request;

    // One row of the directed table: the command, the one field it uses, and
    // where the answer can be read off directly, that answer.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] arg;
        logic        pinned;
        t_out_item   want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 25;

    // The directed part runs with every handler enabled. It starts with
    // counter reads straight after reset, then walks through words outside a
    // frame, the unused command, an oversized frame that saturates, an empty
    // block, a normal block with its last payload word, an out-of-range type
    // whose payload is skipped, a begin that drops a block in progress, a
    // block cut short by the frame end, a type without a mask bit, an empty
    // block on the last word of a frame, a header that is itself the last
    // word with payload still owed, and finally counter reads.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ,   32'd0,         1'b1,
          '{KIND_READBACK, 16'd0,  16'd0, 32'd0,         1'b0, 1'b0, 32'd0}},
        '{CMD_READ,   32'd15,        1'b1,
          '{KIND_READBACK, 16'd15, 16'd0, 32'd0,         1'b0, 1'b0, 32'd0}},
        '{CMD_DATA,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{CMD_BEGIN,  32'd127,       1'b0, NO_RESULT},
        '{CMD_DATA,   32'h000F_0000, 1'b1,
          '{KIND_HEADER,   16'd15, 16'd0, 32'd0,         1'b1, 1'b0, 32'd0}},
        '{CMD_DATA,   32'h0003_0005, 1'b1,
          '{KIND_HEADER,   16'd3,  16'd5, 32'd0,         1'b0, 1'b0, 32'd0}},
        '{CMD_DATA,   32'hFFFF_FFFF, 1'b1,
          '{KIND_PAYLOAD,  16'd3,  16'd5, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0}},
        '{CMD_DATA,   32'h0000_0000, 1'b1,
          '{KIND_PAYLOAD,  16'd3,  16'd5, 32'd0,         1'b1, 1'b0, 32'd0}},
        '{CMD_DATA,   32'h0000_0000, 1'b1,
          '{KIND_HEADER,   16'd0,  16'd0, 32'd0,         1'b1, 1'b0, 32'd0}},
        '{CMD_DATA,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0001_0004, 1'b0, NO_RESULT},
        '{CMD_BEGIN,  32'd0,         1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0001_0004, 1'b0, NO_RESULT},
        '{CMD_BEGIN,  32'd2,         1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0001_0008, 1'b1,
          '{KIND_HEADER,   16'd1,  16'd8, 32'd0,         1'b0, 1'b0, 32'd0}},
        '{CMD_DATA,   32'h1234_5678, 1'b1,
          '{KIND_PAYLOAD,  16'd1,  16'd8, 32'h1234_5678, 1'b1, 1'b1, 32'd0}},
        '{CMD_BEGIN,  32'd3,         1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0010_0004, 1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0002_0000, 1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0002_0000, 1'b1,
          '{KIND_HEADER,   16'd2,  16'd0, 32'd0,         1'b1, 1'b0, 32'd0}},
        '{CMD_BEGIN,  32'd1,         1'b0, NO_RESULT},
        '{CMD_DATA,   32'h0005_0004, 1'b1,
          '{KIND_HEADER,   16'd5,  16'd4, 32'd0,         1'b1, 1'b1, 32'd0}},
        '{CMD_READ,   32'd3,         1'b1,
          '{KIND_READBACK, 16'd3,  16'd0, 32'd0,         1'b0, 1'b0, 32'd1}},
        '{CMD_READ,   32'd15,        1'b1,
          '{KIND_READBACK, 16'd15, 16'd0, 32'd0,         1'b0, 1'b0, 32'd1}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [MASK_W-1:0] i_cfg_data;

    typed_block_deframer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Requests waiting to be offered, and results the block still owes us.
    t_request  request_q [$];
    t_out_item expected_outputs [$];
    t_request  cur_req;
    bit        req_accepted = 1'b0;
    bit        idle_on = 1'b1;
    int        holdoff_left = 0;
    int        mismatches = 0;

    // Our own copy of the deframer state, updated once per accepted request.
    logic [MASK_W-1:0] handler_mask = '0;
    int                frame_left = 0;
    int                payload_left = 0;
    logic [15:0]       cur_type = '0;
    logic [15:0]       cur_len = '0;
    logic              cur_fwd = 1'b0;
    logic [31:0]       type_counts [NUM_TYPES] = '{default: '0};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advances the predicted state by one request and tells whether the block
    // should answer it; the answer itself goes to res.
    function automatic bit deframe_request(input t_in_item req, output t_out_item res);
        logic [31:0] w;
        logic        ended;
        res = '0;
        case (req.command)
            CMD_BEGIN: begin
                frame_left   = (int'(req.frame_words) > FRAME_WORDS_MAX)
                             ? FRAME_WORDS_MAX : int'(req.frame_words);
                payload_left = 0;
                cur_fwd      = 1'b0;
                return 1'b0;
            end
            CMD_READ: begin
                res.kind       = KIND_READBACK;
                res.block_type = 16'(req.type_index);
                res.type_count = (req.type_index < NUM_TYPES) ? type_counts[req.type_index]
                                                              : 32'd0;
                return 1'b1;
            end
            CMD_DATA: begin
                if (frame_left == 0) begin
                    return 1'b0;
                end
                w = req.data_word;
                frame_left--;
                ended = (frame_left == 0);
                if (payload_left == 0) begin
                    // This word is a block header.
                    cur_type = w[31:16];
                    cur_len  = w[15:0];
                    cur_fwd  = 1'b0;
                    if (cur_type < NUM_TYPES) begin
                        type_counts[cur_type[TYPE_W-1:0]] =
                            type_counts[cur_type[TYPE_W-1:0]] + 32'd1;
                        if (cur_type < MASK_W) begin
                            cur_fwd = handler_mask[cur_type[3:0]];
                        end
                    end
                    payload_left = (int'(cur_len) + 3) >> 2;
                    res.kind     = KIND_HEADER;
                end else begin
                    payload_left--;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_word = w;
                end
                res.block_type    = cur_type;
                res.byte_length   = cur_len;
                res.last_of_block = (payload_left == 0) || ended;
                res.truncated     = (payload_left != 0) && ended;
                if (ended) begin
                    payload_left = 0;
                end
                return cur_fwd;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task automatic check_output(input t_out_item got, input t_out_item want);
        if (got.kind !== want.kind) begin
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        end
        if (got.block_type !== want.block_type) begin
            report_mismatch("block_type", 32'(got.block_type), 32'(want.block_type));
        end
        if (got.byte_length !== want.byte_length) begin
            report_mismatch("byte_length", 32'(got.byte_length), 32'(want.byte_length));
        end
        if (got.payload_word !== want.payload_word) begin
            report_mismatch("payload_word", got.payload_word, want.payload_word);
        end
        if (got.last_of_block !== want.last_of_block) begin
            report_mismatch("last_of_block", 32'(got.last_of_block),
                            32'(want.last_of_block));
        end
        if (got.truncated !== want.truncated) begin
            report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
        end
        if (got.type_count !== want.type_count) begin
            report_mismatch("type_count", got.type_count, want.type_count);
        end
    endtask

    // Queues one request. The fields the command does not use get random
    // values, so the block is also shown that it must ignore them.
    function automatic void push_request(input logic [1:0] cmd, input logic [31:0] arg,
                                         input logic pinned, input t_out_item want);
        t_request r;
        r.item.command     = cmd;
        r.item.frame_words = 7'($urandom);
        r.item.data_word   = $urandom;
        r.item.type_index  = 4'($urandom);
        case (cmd)
            CMD_BEGIN: r.item.frame_words = arg[6:0];
            CMD_DATA:  r.item.data_word   = arg;
            CMD_READ:  r.item.type_index  = arg[3:0];
            default:   ;
        endcase
        r.pinned = pinned;
        r.want   = want;
        request_q.push_back(r);
    endfunction

    // Queues one frame: mostly well-formed blocks with random types, lengths
    // and payload, sometimes cut short by the next begin or run past its end,
    // with counter reads and stray requests mixed in. Returns how many of the
    // queued requests do real work.
    function automatic int queue_random_frame();
        int          n;
        int          budget;
        int          words;
        int          len;
        int          pay;
        int          k;
        int          counted;
        logic [15:0] btype;
        logic [15:0] blen;
        counted = 0;
        if ($urandom_range(0, 11) == 0) begin
            push_request($urandom_range(0, 1) ? CMD_UNUSED : CMD_DATA, $urandom,
                         1'b0, NO_RESULT);
        end
        case ($urandom_range(0, 19))
            0:       n = 0;
            1, 2:    n = $urandom_range(FRAME_WORDS_MAX, 127);
            default: n = $urandom_range(1, 16);
        endcase
        push_request(CMD_BEGIN, 32'(n), 1'b0, NO_RESULT);
        counted++;
        budget = (n > FRAME_WORDS_MAX) ? FRAME_WORDS_MAX : n;
        case ($urandom_range(0, 9))
            0:       budget = budget - $urandom_range(0, budget);
            1:       budget = budget + $urandom_range(1, 4);
            default: ;
        endcase
        words = 0;
        while (words < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                push_request(CMD_READ, $urandom, 1'b0, NO_RESULT);
                counted++;
            end
            if ($urandom_range(0, 9) == 0) begin
                btype = 16'($urandom_range(NUM_TYPES, 65535));
            end else begin
                btype = 16'($urandom_range(0, NUM_TYPES - 1));
            end
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(0, 65535);
                1, 2:    len = $urandom_range(0, 255);
                default: len = $urandom_range(0, 20);
            endcase
            blen = 16'(len);
            push_request(CMD_DATA, {btype, blen}, 1'b0, NO_RESULT);
            words++;
            counted++;
            pay = (len + 3) / 4;
            for (k = 0; k < pay && words < budget; k++) begin
                push_request(CMD_DATA, $urandom, 1'b0, NO_RESULT);
                words++;
                counted++;
                if ($urandom_range(0, 11) == 0) begin
                    push_request(CMD_READ, $urandom, 1'b0, NO_RESULT);
                    counted++;
                end
            end
        end
        return counted;
    endfunction

    // The mask register may only change while nothing is in flight; callers
    // drain the block first.
    task automatic write_handler_mask(input logic [MASK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        handler_mask = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued request has been taken and every owed result
    // has come back, then lets the pipeline settle, since requests that give
    // no result may still be inside the block.
    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request sender. A request stays on the bus, unchanged, until it is
    // accepted; after an acceptance the sender may pause for a short burst.
    initial begin : request_sender
        int gap_left;
        gap_left   = 0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        forever begin
            @(negedge i_clk);
            if (!i_in_valid || req_accepted) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= cur_req.item;
                    if (idle_on && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 3);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. Besides short random stalls it can hold off for a long
    // stretch, which fills the block and pushes the stall back to the sender.
    initial begin : result_receiver
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Scoreboard. Each accepted request runs through the predictor; a result
    // it owes joins the back of the queue, and each accepted result is
    // compared against the front.
    always @(posedge i_clk) begin : scoreboard
        t_out_item predicted;
        bit        owes_result;
        req_accepted = i_rst_n && i_in_valid && !o_in_stall;
        if (req_accepted) begin
            owes_result = deframe_request(cur_req.item, predicted);
            if (cur_req.pinned) begin
                expected_outputs.push_back(cur_req.want);
            end else if (owes_result) begin
                expected_outputs.push_back(predicted);
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("result with none owed, kind", 32'(o_out_data.kind), 32'd0);
            end else begin
                check_output(o_out_data, expected_outputs.pop_front());
            end
        end
    end

    // Watchdog: ends the run if no request, result or register write moves
    // for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : main_sequence
        int              p;
        int              queued;
        logic [MASK_W-1:0] mask;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with every handler enabled.
        write_handler_mask('1);
        for (p = 0; p < DIRECTED_ROWS; p++) begin
            push_request(directed_rows[p].cmd, directed_rows[p].arg,
                         directed_rows[p].pinned, directed_rows[p].want);
        end
        wait_drained();

        // Random phases, each under its own mask: all off, all on with a long
        // receiver hold-off, then random masks. The last phase runs with no
        // idling on either side.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       mask = '0;
                1:       mask = '1;
                default: mask = MASK_W'($urandom);
            endcase
            if (p == RANDOM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            write_handler_mask(mask);
            if (p == 1) begin
                holdoff_left = HOLDOFF_CYCLES;
            end
            queued = 0;
            while (queued < PHASE_REQUESTS) begin
                queued += queue_random_frame();
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
